>>> sv/ppl_pkg.sv
// ppl_pkg: shared types and constants for the ping-pong log buffer
// holds the action codes and the request and response item structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppl_pkg;

   // default capacity of one buffer in bytes
   localparam int BUF_SIZE = 256;

   // action codes carried by a request item
   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_LOCK    = 2'd1,
      ACT_READ    = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   // request item
   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic        start_of_message;
      logic [8:0]  message_size;
      logic [7:0]  read_index;
   } req_type;

   // response item
   typedef struct packed {
      logic [7:0]  read_byte;
      logic [8:0]  reported_size;
      logic        write_accepted;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/ping_pong_log_buffer_top.sv
// ping_pong_log_buffer_top: two byte buffers written and read ping-pong style
// uses ppl_pkg for the item structs, action codes and default capacity
`timescale 1ns / 1ps
`default_nettype none

//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+------------------------
//  request | req_valid req_stall req_data   | in        | one action item
//  result  | rsp_valid rsp_stall rsp_data   | out       | one result item per request
//
//  every item gives its result in the cycle after it is accepted; the buffer
//  state sits in flops and one byte memory of 2*BUF_SIZE entries whose read
//  port is registered, so the read byte is ready along with the result.
//  one item per cycle is taken while the result register is empty or drained.
//  a stalled result holds; req_stall is raised while it waits.
//  synchronous reset clears all control state; the byte memory is not cleared.

module ping_pong_log_buffer_top #(
   parameter int BUF_SIZE = ppl_pkg::BUF_SIZE
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  ppl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output ppl_pkg::rsp_type rsp_data
);

   localparam int FW  = $clog2(BUF_SIZE + 1);
   localparam int SW  = ((FW > 9) ? FW : 9) + 1;
   localparam int MAW = $clog2(2 * BUF_SIZE);
   localparam logic [SW-1:0]  BUF_LIMIT = SW'(BUF_SIZE);
   localparam logic [MAW-1:0] BUF_BASE  = MAW'(BUF_SIZE);

   // control state
   logic [FW-1:0] fill0_ff, fill0_in, fill1_ff, fill1_in;
   logic [FW-1:0] held0_ff, held0_in, held1_ff, held1_in;
   logic          write_sel_ff, write_sel_in;
   logic          lock_held_ff, lock_held_in;
   logic          lock_sel_ff, lock_sel_in;
   logic [8:0]    bytes_left_ff, bytes_left_in;
   logic          msg_buf_ff, msg_buf_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          hit_ff, hit_in;
   logic [8:0]    size_ff, size_in;
   logic          acc_ff, acc_in;

   // byte memory
   logic [7:0]     byte_store [2*BUF_SIZE];
   logic [7:0]     mem_q_ff;
   logic           wr_en, rd_en;
   logic [MAW-1:0] wr_addr, rd_addr;

   // working values
   logic          accept;
   logic          ws, alt;
   logic [FW-1:0] fill_ws, fill_alt, pos, held_ls;
   logic [SW-1:0] size_x, ridx_x;
   logic [8:0]    eff_left;
   logic          eff_buf;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign ws       = write_sel_ff;
   assign alt      = ~write_sel_ff;
   assign fill_ws  = ws ? fill1_ff : fill0_ff;
   assign fill_alt = ws ? fill0_ff : fill1_ff;
   assign held_ls  = lock_sel_ff ? held1_ff : held0_ff;
   assign size_x   = SW'(req_data.message_size);
   assign ridx_x   = SW'(req_data.read_index);

   // open a message and pick where it goes
   always_comb begin
      eff_left = bytes_left_ff;
      eff_buf  = msg_buf_ff;
      if (req_data.start_of_message) begin
         eff_left = '0;
         if (size_x != '0 && size_x <= BUF_LIMIT) begin
            if (SW'(fill_ws) + size_x > BUF_LIMIT) begin
               if (fill_alt == '0 && !(lock_held_ff && lock_sel_ff == alt)) begin
                  eff_buf  = alt;
                  eff_left = req_data.message_size;
               end
            end else begin
               eff_buf  = ws;
               eff_left = req_data.message_size;
            end
         end
      end
   end

   assign pos = eff_buf ? fill1_ff : fill0_ff;

   // action decode and next state
   always_comb begin
      fill0_in      = fill0_ff;
      fill1_in      = fill1_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      write_sel_in  = write_sel_ff;
      lock_held_in  = lock_held_ff;
      lock_sel_in   = lock_sel_ff;
      bytes_left_in = bytes_left_ff;
      msg_buf_in    = msg_buf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      hit_in        = hit_ff;
      size_in       = size_ff;
      acc_in        = acc_ff;
      wr_en         = 1'b0;
      wr_addr       = MAW'(pos) + (eff_buf ? BUF_BASE : '0);
      rd_en         = 1'b0;
      rd_addr       = MAW'(req_data.read_index) + (lock_sel_ff ? BUF_BASE : '0);
      if (accept) begin
         rsp_valid_in = 1'b1;
         hit_in       = 1'b0;
         size_in      = '0;
         acc_in       = 1'b0;
         unique case (req_data.action)
            ppl_pkg::ACT_WRITE: begin
               if (req_data.start_of_message && eff_buf != msg_buf_ff) begin
                  msg_buf_in = eff_buf;
               end
               if (req_data.start_of_message) begin
                  write_sel_in = eff_buf;
                  msg_buf_in   = eff_buf;
                  if (eff_left == '0) begin
                     write_sel_in = write_sel_ff;
                     msg_buf_in   = msg_buf_ff;
                  end
               end
               bytes_left_in = eff_left;
               // store the byte if the message is open and there is room
               if (eff_left != '0 && SW'(pos) < BUF_LIMIT) begin
                  wr_en         = 1'b1;
                  acc_in        = 1'b1;
                  bytes_left_in = eff_left - 9'd1;
                  if (eff_buf) fill1_in = pos + FW'(1);
                  else         fill0_in = pos + FW'(1);
               end
            end
            ppl_pkg::ACT_LOCK: begin
               if (fill_ws != '0) begin
                  lock_held_in  = 1'b1;
                  lock_sel_in   = ws;
                  write_sel_in  = alt;
                  bytes_left_in = '0;
                  size_in       = 9'(SW'(fill_ws));
                  if (ws) begin
                     held1_in = fill_ws;
                     fill0_in = '0;
                  end else begin
                     held0_in = fill_ws;
                     fill1_in = '0;
                  end
               end
            end
            ppl_pkg::ACT_READ: begin
               rd_en = 1'b1;
               if (lock_held_ff && ridx_x < SW'(held_ls) && ridx_x < BUF_LIMIT) begin
                  hit_in = 1'b1;
               end
            end
            ppl_pkg::ACT_RELEASE: begin
               if (lock_held_ff && held_ls != '0) begin
                  size_in      = 9'(SW'(held_ls));
                  lock_held_in = 1'b0;
                  if (lock_sel_ff) begin
                     held1_in = '0;
                     fill1_in = '0;
                  end else begin
                     held0_in = '0;
                     fill0_in = '0;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill0_ff      <= '0;
         fill1_ff      <= '0;
         held0_ff      <= '0;
         held1_ff      <= '0;
         write_sel_ff  <= 1'b0;
         lock_held_ff  <= 1'b0;
         lock_sel_ff   <= 1'b0;
         bytes_left_ff <= '0;
         msg_buf_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill0_ff      <= fill0_in;
         fill1_ff      <= fill1_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         write_sel_ff  <= write_sel_in;
         lock_held_ff  <= lock_held_in;
         lock_sel_ff   <= lock_sel_in;
         bytes_left_ff <= bytes_left_in;
         msg_buf_ff    <= msg_buf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      size_ff <= size_in;
      acc_ff  <= acc_in;
   end

   // byte memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store[wr_addr] <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= byte_store[rd_addr];
      end
   end

   // result outputs
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.read_byte      = hit_ff ? mem_q_ff : 8'd0;
   assign rsp_data.reported_size  = size_ff;
   assign rsp_data.write_accepted = acc_ff;

   // the write buffer is never the locked one
   a_write_not_locked: assert property (@(posedge clock) disable iff (reset)
      lock_held_ff |-> write_sel_ff != lock_sel_ff)
      else $error("write buffer is the locked buffer");

   // an open message never targets the locked buffer
   a_msg_not_locked: assert property (@(posedge clock) disable iff (reset)
      (bytes_left_ff != '0 && lock_held_ff) |-> msg_buf_ff != lock_sel_ff)
      else $error("open message targets the locked buffer");

   // fill counts stay within capacity
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      SW'(fill0_ff) <= BUF_LIMIT && SW'(fill1_ff) <= BUF_LIMIT)
      else $error("fill count above capacity");

   // every accepted item yields a pending result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item left no result");

endmodule

`default_nettype wire

>>> bench/ppl_bench_pkg.sv
// ppl_bench_pkg: scoreboard for the ping-pong log buffer bench
// predicts one result per request item and checks results in order
// depends on ppl_pkg for the item structs, action codes and capacity
`timescale 1ns / 1ps

package ppl_bench_pkg;
   import ppl_pkg::*;

   localparam int unsigned CAP = BUF_SIZE;

   class log_buffer_scoreboard;
      // mirror of the two buffers and their control state
      bit [7:0]    mem [0:2*CAP-1];
      int unsigned fill [2];
      int unsigned held [2];
      bit          wr_sel;
      bit          lock_on;
      bit          lock_sel;
      bit          msg_buf;
      int unsigned left;

      // results still owed by the block, oldest first
      rsp_type     awaited_rsps [$];

      int unsigned errors;
      int unsigned noted;
      int unsigned checked;
      int unsigned bytes_kept;
      int unsigned bytes_dropped;
      int unsigned locks_taken;

      // opener decides the target buffer or drops the message
      function bit open_msg(int unsigned size);
         bit w;
         w = wr_sel;
         left = 0;
         if (size == 0 || size > CAP) return 1'b0;
         if (fill[w] + size > CAP) begin
            if (fill[~w] != 0 || (lock_on && lock_sel == ~w)) return 1'b0;
            wr_sel = ~w;
            w = ~w;
         end
         msg_buf = w;
         left = size;
         return 1'b1;
      endfunction

      // store one byte of the open message
      function bit put_byte(bit [7:0] d);
         if (left == 0 || fill[msg_buf] >= CAP) return 1'b0;
         mem[int'(msg_buf) * CAP + fill[msg_buf]] = d;
         fill[msg_buf]++;
         left--;
         return 1'b1;
      endfunction

      // predict the result of one accepted request item
      function void note_request(req_type r);
         rsp_type     want;
         bit          ok;
         bit          w;
         int unsigned sz;
         int unsigned ridx;
         want = '0;
         ridx = 32'(r.read_index);
         noted++;
         case (r.action)
            ACT_WRITE: begin
               ok = 1'b1;
               if (r.start_of_message) ok = open_msg(32'(r.message_size));
               if (ok && put_byte(r.data_byte)) begin
                  want.write_accepted = 1'b1;
                  bytes_kept++;
               end else begin
                  bytes_dropped++;
               end
            end
            ACT_LOCK: begin
               w = wr_sel;
               sz = fill[w];
               if (sz != 0) begin
                  lock_on = 1'b1;
                  lock_sel = w;
                  held[w] = sz;
                  wr_sel = ~w;
                  fill[~w] = 0;
                  left = 0;
                  want.reported_size = sz[8:0];
                  locks_taken++;
               end
            end
            ACT_READ: begin
               if (lock_on && ridx < held[lock_sel])
                  want.read_byte = mem[int'(lock_sel) * CAP + ridx];
            end
            default: begin
               if (lock_on && held[lock_sel] != 0) begin
                  want.reported_size = held[lock_sel][8:0];
                  held[lock_sel] = 0;
                  fill[lock_sel] = 0;
                  lock_on = 1'b0;
               end
            end
         endcase
         awaited_rsps.push_back(want);
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_rsps.size() == 0) begin
            $display("%0t: unexpected result item, nothing awaited, got %h", $time, got);
            errors++;
            return;
         end
         want = awaited_rsps.pop_front();
         checked++;
         if (got.read_byte !== want.read_byte) begin
            $display("%0t: read_byte expected %0h, got %0h",
                     $time, want.read_byte, got.read_byte);
            errors++;
         end
         if (got.reported_size !== want.reported_size) begin
            $display("%0t: reported_size expected %0d, got %0d",
                     $time, want.reported_size, got.reported_size);
            errors++;
         end
         if (got.write_accepted !== want.write_accepted) begin
            $display("%0t: write_accepted expected %0b, got %0b",
                     $time, want.write_accepted, got.write_accepted);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return awaited_rsps.size();
      endfunction

      // size of the locked buffer, zero when nothing is locked
      function int unsigned locked_fill();
         return lock_on ? held[lock_sel] : 0;
      endfunction
   endclass

endpackage

>>> bench/tb_ping_pong_log_buffer_top.sv
// tb_ping_pong_log_buffer_top: bench for the ping-pong log buffer
// directed corner items, then random message sequences with random idling
// depends on ppl_pkg, ppl_bench_pkg and ping_pong_log_buffer_top
`timescale 1ns / 1ps

module tb_ping_pong_log_buffer_top;
   import ppl_pkg::*;
   import ppl_bench_pkg::*;

   localparam int ITEMS       = 750;
   localparam int HOLD_CYCLES = 60;
   localparam int TAIL_CYCLES = 10;
   localparam int LIMIT       = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   log_buffer_scoreboard sb = new();

   int cycle_count = 0;
   int sent = 0;
   int burst_left = 0;

   ping_pong_log_buffer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("tb_ping_pong_log_buffer_top: done, errors");
         $finish;
      end
   end

   // note accepted requests, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // result side stall pattern, with two long hold-offs to back up the block
   initial begin : receiver
      int rx_cycle;
      int holds_done;
      rx_cycle = 0;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (holds_done < 2 && sb.noted >= (holds_done == 0 ? 150 : 450)) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            case ((rx_cycle / 48) % 4)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= (rx_cycle % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 2) != 0);
            endcase
         end
      end
   end

   // item of the given action with every other field random
   function automatic req_type rand_item(action_type a);
      req_type r;
      r.action = a;
      r.data_byte = 8'($urandom);
      r.start_of_message = 1'($urandom);
      r.message_size = 9'($urandom);
      r.read_index = 8'($urandom);
      return r;
   endfunction

   // offer one item in bursts with random gaps, return once it is taken
   task automatic send_item(req_type r);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_write(logic [7:0] d, bit som, int size);
      req_type r;
      r = rand_item(ACT_WRITE);
      r.data_byte = d;
      r.start_of_message = som;
      if (som) r.message_size = size[8:0];
      send_item(r);
   endtask

   task automatic send_read(logic [7:0] idx);
      req_type r;
      r = rand_item(ACT_READ);
      r.read_index = idx;
      send_item(r);
   endtask

   // opener plus following bytes, nbytes in all
   task automatic send_message(int size, int nbytes);
      send_write(8'($urandom), 1'b1, size);
      for (int i = 1; i < nbytes; i++) send_write(8'($urandom), 1'b0, 0);
   endtask

   // corner cases
   task automatic run_directed();
      // release, read and lock with nothing there
      send_item(rand_item(ACT_RELEASE));
      send_read(8'd0);
      send_item(rand_item(ACT_LOCK));
      // byte with no open message
      send_write(8'h5A, 1'b0, 0);
      // zero size and over-capacity openers, follower dropped
      send_write(8'h11, 1'b1, 0);
      send_write(8'h22, 1'b0, 0);
      send_write(8'h33, 1'b1, 300);
      // clean message with extreme bytes
      send_write(8'h00, 1'b1, 3);
      send_write(8'hFF, 1'b0, 0);
      send_write(8'hA5, 1'b0, 0);
      // new opener abandons the rest of the previous message
      send_write(8'h01, 1'b1, 4);
      send_write(8'h02, 1'b0, 0);
      send_write(8'h03, 1'b1, 1);
      // lock, read inside, at and past the locked size
      send_item(rand_item(ACT_LOCK));
      send_read(8'd0);
      send_read(8'd5);
      send_read(8'd6);
      send_read(8'd255);
      // full-capacity opener, then lock while locked and mid-message
      send_write(8'hC3, 1'b1, 256);
      send_write(8'h3C, 1'b0, 0);
      send_item(rand_item(ACT_LOCK));
      send_write(8'h77, 1'b0, 0);
      send_read(8'd1);
      // release twice, the second finds nothing
      send_item(rand_item(ACT_RELEASE));
      send_item(rand_item(ACT_RELEASE));
   endtask

   // mostly well-formed messages, locks, reads and releases, some noise
   task automatic run_random();
      int pick;
      int size;
      int n;
      int lf;
      while (sent < ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            n = $urandom_range(0, 99);
            if (n < 60) begin
               // short message, now and then one stray byte after it
               size = $urandom_range(1, 16);
               send_message(size, ($urandom_range(0, 9) == 0) ? size + 1 : size);
            end else if (n < 80) begin
               // big opener cut short, pushes buffers toward no room
               send_message($urandom_range(180, 256), $urandom_range(1, 3));
            end else begin
               size = $urandom_range(17, 48);
               send_message(size, size);
            end
         end else if (pick < 67) begin
            send_item(rand_item(ACT_LOCK));
         end else if (pick < 82) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               lf = sb.locked_fill();
               if (lf != 0 && $urandom_range(0, 3) != 0)
                  send_read(8'($urandom_range(0, lf - 1)));
               else
                  send_read(8'($urandom_range(0, 255)));
            end
         end else if (pick < 90) begin
            send_item(rand_item(ACT_RELEASE));
         end else begin
            send_item(rand_item(action_type'($urandom_range(0, 3))));
         end
      end
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d items and %0d results: %0d bytes stored, %0d dropped,",
               sent, sb.checked, sb.bytes_kept, sb.bytes_dropped);
      $display("%0d nonempty locks, with two long result hold-offs", sb.locks_taken);
      if (sb.errors == 0) begin
         $display("tb_ping_pong_log_buffer_top: done, clean");
      end else begin
         $display("tb_ping_pong_log_buffer_top: done, errors");
      end
      $finish;
   end

endmodule
